// ===== rtl/f2ha_pkg.sv =====
// Shared types and constants for the float-to-hundredths text formatter.
package f2ha_pkg;

  localparam int unsigned NumDigits    = 6;
  localparam int unsigned DivStages    = NumDigits - 1;
  localparam int unsigned FifoDepthDef = 4;

  localparam logic [7:0]  ExpLow     = 8'd119;
  localparam logic [7:0]  ExpTop     = 8'd150;
  localparam logic [19:0] HundMax    = 20'd999999;
  localparam logic [30:0] InfBits    = 31'h7F80_0000;
  // ceil(2^23 / 10); exact floor division by ten for every value below 2^22.
  localparam logic [19:0] RecipTen   = 20'd838861;

  localparam logic [7:0]  ChMinus    = 8'h2D;
  localparam logic [7:0]  ChDot      = 8'h2E;
  localparam logic [7:0]  ChZero     = 8'h30;

  // Character slots of the fixed eight-position layout "-DDDD.DD".
  localparam logic [2:0]  SlotSign   = 3'd0;
  localparam logic [2:0]  SlotThou   = 3'd1;
  localparam logic [2:0]  SlotHund   = 3'd2;
  localparam logic [2:0]  SlotTens   = 3'd3;
  localparam logic [2:0]  SlotOnes   = 3'd4;
  localparam logic [2:0]  SlotDot    = 3'd5;
  localparam logic [2:0]  SlotTenth  = 3'd6;
  localparam logic [2:0]  SlotLast   = 3'd7;

  typedef struct packed {
    logic                       neg;
    logic [NumDigits-1:0][3:0] digit;  // digit[0] is the hundredths digit
  } f2ha_rec_t;

endpackage

// ===== rtl/f2ha_front.sv =====
// Front pipeline: scales and rounds the value, then splits it into decimal digits.
module f2ha_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [31:0]         float_bits_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output f2ha_pkg::f2ha_rec_t out_rec_o
);
  import f2ha_pkg::*;

  logic en;

  // Stage 1: classification and the product with one hundred.
  logic        s1_valid_q;
  logic        s1_neg_q, s1_zero_q, s1_sat_q;
  logic [4:0]  s1_sh_q;
  logic [30:0] s1_scaled_q;

  logic [7:0]  exp_w;
  logic [23:0] mant_w;
  logic        neg_w, zero_w, sat_w;
  logic [7:0]  sh_full_w;

  assign exp_w     = float_bits_i[30:23];
  assign mant_w    = {1'b1, float_bits_i[22:0]};
  assign neg_w     = float_bits_i[31] && (float_bits_i[30:0] != 31'd0) &&
                     (float_bits_i[30:0] <= InfBits);
  assign zero_w    = (exp_w == 8'd0) || (exp_w < ExpLow);
  assign sat_w     = (exp_w >= ExpTop);
  assign sh_full_w = ExpTop - exp_w;

  // Stage 2: shift, round half to even, saturate.
  logic        s2_valid_q;
  logic        s2_neg_q;
  logic [19:0] s2_hund_q;

  logic [30:0] quo_w, rem_w, mask_w, half_w;
  logic        rnd_w;
  logic [31:0] rounded_w;
  logic [19:0] hund_w;

  assign quo_w     = s1_scaled_q >> s1_sh_q;
  assign mask_w    = (31'd1 << s1_sh_q) - 31'd1;
  assign rem_w     = s1_scaled_q & mask_w;
  assign half_w    = 31'd1 << (s1_sh_q - 5'd1);
  assign rnd_w     = (rem_w > half_w) || ((rem_w == half_w) && quo_w[0]);
  assign rounded_w = 32'(quo_w) + 32'(rnd_w);

  always_comb begin
    if (s1_zero_q) begin
      hund_w = 20'd0;
    end else if (s1_sat_q || (rounded_w >= 32'(HundMax))) begin
      hund_w = HundMax;
    end else begin
      hund_w = rounded_w[19:0];
    end
  end

  // Digit stages: each peels the lowest decimal digit off the running value.
  logic                       dv_q   [DivStages];
  logic                       dneg_q [DivStages];
  logic [19:0]                dval_q [DivStages];
  logic [NumDigits-1:0][3:0]  ddig_q [DivStages];

  logic                       iv_w   [DivStages];
  logic                       ineg_w [DivStages];
  logic [19:0]                ival_w [DivStages];
  logic [NumDigits-1:0][3:0]  idig_w [DivStages];
  logic [NumDigits-1:0][3:0]  odig_w [DivStages];
  logic [19:0]                quot_w [DivStages];
  logic [3:0]                 dig_w  [DivStages];

  for (genvar k = 0; k < DivStages; k++) begin : g_div
    logic [39:0] prod;
    logic [16:0] q17;
    logic [19:0] times_ten;
    logic [NumDigits-1:0][3:0] nxt_dig;

    if (k == 0) begin : g_first
      assign iv_w[k]   = s2_valid_q;
      assign ineg_w[k] = s2_neg_q;
      assign ival_w[k] = s2_hund_q;
      assign idig_w[k] = '0;
    end else begin : g_next
      assign iv_w[k]   = dv_q[k-1];
      assign ineg_w[k] = dneg_q[k-1];
      assign ival_w[k] = dval_q[k-1];
      assign idig_w[k] = ddig_q[k-1];
    end

    assign prod      = 40'(ival_w[k]) * 40'(RecipTen);
    assign q17       = prod[39:23];
    assign quot_w[k] = 20'(q17);
    assign times_ten = 20'({q17, 3'b000}) + 20'({q17, 1'b0});
    assign dig_w[k]  = 4'(ival_w[k] - times_ten);

    // Digits from earlier stages pass through; this stage fills in its own.
    always_comb begin
      nxt_dig    = idig_w[k];
      nxt_dig[k] = dig_w[k];
    end
    assign odig_w[k] = nxt_dig;
  end

  localparam int unsigned LastStg = DivStages - 1;

  assign en          = !(dv_q[LastStg] && !out_ready_i);
  assign in_ready_o  = en;
  assign out_valid_o = dv_q[LastStg];

  always_comb begin
    out_rec_o.neg   = dneg_q[LastStg];
    out_rec_o.digit = ddig_q[LastStg];
    out_rec_o.digit[NumDigits-1] = dval_q[LastStg][3:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      for (int k = 0; k < DivStages; k++) begin
        dv_q[k] <= 1'b0;
      end
    end else if (en) begin
      s1_valid_q <= in_valid_i;
      s2_valid_q <= s1_valid_q;
      for (int k = 0; k < DivStages; k++) begin
        dv_q[k] <= iv_w[k];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_neg_q    <= neg_w;
      s1_zero_q   <= zero_w;
      s1_sat_q    <= sat_w;
      s1_sh_q     <= sh_full_w[4:0];
      s1_scaled_q <= 31'({mant_w, 6'b0}) + 31'({mant_w, 5'b0}) + 31'({mant_w, 2'b0});
      s2_neg_q    <= s1_neg_q;
      s2_hund_q   <= hund_w;
      for (int k = 0; k < DivStages; k++) begin
        dneg_q[k] <= ineg_w[k];
        dval_q[k] <= quot_w[k];
        ddig_q[k] <= odig_w[k];
      end
    end
  end

endmodule

// ===== rtl/f2ha_fifo.sv =====
// Small request queue between the digit pipeline and the character serializer.
module f2ha_fifo #(
  parameter int unsigned FifoDepth = f2ha_pkg::FifoDepthDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_valid_i,
  output logic                push_ready_o,
  input  f2ha_pkg::f2ha_rec_t push_data_i,
  output logic                pop_valid_o,
  input  logic                pop_ready_i,
  output f2ha_pkg::f2ha_rec_t pop_data_o
);
  import f2ha_pkg::*;

  localparam int unsigned PtrW = $clog2(FifoDepth);
  localparam int unsigned CntW = $clog2(FifoDepth + 1);

  f2ha_rec_t       mem_q [FifoDepth];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            push, pop;

  assign push_ready_o = (cnt_q != CntW'(FifoDepth));
  assign pop_valid_o  = (cnt_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_ready_i && pop_valid_o;
  assign pop_data_o   = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push) begin
      wr_d = (wr_q == PtrW'(FifoDepth - 1)) ? '0 : wr_q + PtrW'(1);
    end
    if (pop) begin
      rd_d = (rd_q == PtrW'(FifoDepth - 1)) ? '0 : rd_q + PtrW'(1);
    end
    if (push && !pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (pop && !push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

endmodule

// ===== rtl/f2ha_back.sv =====
// Back end: turns one digit record into a run of ASCII characters.
module f2ha_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                rec_valid_i,
  output logic                rec_ready_o,
  input  f2ha_pkg::f2ha_rec_t rec_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [7:0]          text_char_o,
  output logic                last_o
);
  import f2ha_pkg::*;

  // Slots that print for a record; leading zeros of the integer part are dropped.
  function automatic logic [7:0] keep_mask(f2ha_rec_t r);
    logic [7:0] m;
    m           = 8'hF0;
    m[SlotSign] = r.neg;
    m[SlotThou] = (r.digit[5] != 4'd0);
    m[SlotHund] = (r.digit[5] != 4'd0) || (r.digit[4] != 4'd0);
    m[SlotTens] = (r.digit[5] != 4'd0) || (r.digit[4] != 4'd0) || (r.digit[3] != 4'd0);
    return m;
  endfunction

  // Lowest printing slot at or above the starting slot.
  function automatic logic [2:0] first_kept(logic [7:0] m, logic [3:0] from);
    logic [2:0] s;
    logic       found;
    s     = SlotLast;
    found = 1'b0;
    for (int j = 0; j < 8; j++) begin
      if (!found && m[j] && (4'(j) >= from)) begin
        s     = 3'(j);
        found = 1'b1;
      end
    end
    return s;
  endfunction

  logic       busy_q, busy_d;
  logic [2:0] slot_q, slot_d;
  f2ha_rec_t  rec_q, rec_d;
  logic       ov_q, ov_d;
  logic [7:0] ch_q, ch_d;
  logic       last_q, last_d;

  logic       out_free, emit, fin, load;
  logic [7:0] ch_w;

  assign out_free    = !ov_q || out_ready_i;
  assign emit        = busy_q && out_free;
  assign fin         = emit && (slot_q == SlotLast);
  assign load        = (!busy_q || fin) && rec_valid_i;
  assign rec_ready_o = !busy_q || fin;

  always_comb begin
    case (slot_q)
      SlotSign:  ch_w = ChMinus;
      SlotThou:  ch_w = ChZero + 8'(rec_q.digit[5]);
      SlotHund:  ch_w = ChZero + 8'(rec_q.digit[4]);
      SlotTens:  ch_w = ChZero + 8'(rec_q.digit[3]);
      SlotOnes:  ch_w = ChZero + 8'(rec_q.digit[2]);
      SlotDot:   ch_w = ChDot;
      SlotTenth: ch_w = ChZero + 8'(rec_q.digit[1]);
      default:   ch_w = ChZero + 8'(rec_q.digit[0]);
    endcase
  end

  always_comb begin
    busy_d = busy_q;
    slot_d = slot_q;
    rec_d  = rec_q;
    ov_d   = ov_q && !out_ready_i;
    ch_d   = ch_q;
    last_d = last_q;
    if (emit) begin
      ov_d   = 1'b1;
      ch_d   = ch_w;
      last_d = (slot_q == SlotLast);
      slot_d = first_kept(keep_mask(rec_q), 4'(slot_q) + 4'd1);
    end
    if (fin) begin
      busy_d = 1'b0;
    end
    if (load) begin
      busy_d = 1'b1;
      rec_d  = rec_i;
      slot_d = first_kept(keep_mask(rec_i), 4'd0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      ov_q   <= 1'b0;
      slot_q <= SlotSign;
    end else begin
      busy_q <= busy_d;
      ov_q   <= ov_d;
      slot_q <= slot_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rec_q  <= rec_d;
    ch_q   <= ch_d;
    last_q <= last_d;
  end

  assign out_valid_o = ov_q;
  assign text_char_o = ch_q;
  assign last_o      = last_q;

endmodule

// ===== rtl/float32_to_hundredths_ascii_top.sv =====
// Top level of the single-precision to two-decimal ASCII text formatter.
//
//   Channel | Signals                                  | Carries
//   --------+------------------------------------------+-----------------------------------
//   input   | in_valid_i, in_ready_o, float_bits_i     | one request: raw float32 bits
//   output  | out_valid_o, out_ready_i, text_char_o,   | one ASCII character per transfer,
//           | last_o                                   | last_o set on a value's final one
//
// A request passes a seven-stage front pipeline (scale by one hundred, round half
// to even and saturate, then five divide-by-ten stages) and lands in a small queue.
// The serializer emits one character per cycle while out_ready_i takes them, so a value
// occupies the output for 4 to 8 characters; that serializer sets the sustained rate.
// An isolated request's first character passes the front stages, the queue and the serializer registers.
// Reset clears all valid flags, queue pointers and the serializer; data registers
// are not reset. A stalled output fills the queue, then the front pipeline holds
// in place and in_ready_o drops until the queue has room again.
module float32_to_hundredths_ascii_top #(
  parameter int unsigned FifoDepth = f2ha_pkg::FifoDepthDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [31:0] float_bits_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  text_char_o,
  output logic        last_o
);
  import f2ha_pkg::*;

  // Front to queue.
  logic      fr_valid, fr_ready;
  f2ha_rec_t fr_rec;

  // Queue to serializer.
  logic      bk_valid, bk_ready;
  f2ha_rec_t bk_rec;

  // The front decides the sign and the rounded count of hundredths, and splits
  // that count into six decimal digits, so the back end only has to choose
  // which character slots to print.
  f2ha_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .float_bits_i (float_bits_i),
    .out_valid_o  (fr_valid),
    .out_ready_i  (fr_ready),
    .out_rec_o    (fr_rec)
  );

  // The queue decouples the pipeline from the serializer, which emits each value as
  // a run of characters.
  f2ha_fifo #(
    .FifoDepth (FifoDepth)
  ) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (fr_valid),
    .push_ready_o (fr_ready),
    .push_data_i  (fr_rec),
    .pop_valid_o  (bk_valid),
    .pop_ready_i  (bk_ready),
    .pop_data_o   (bk_rec)
  );

  // The serializer walks the printing slots of the current record and loads
  // the next record in the cycle that its last character is issued.
  f2ha_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rec_valid_i (bk_valid),
    .rec_ready_o (bk_ready),
    .rec_i       (bk_rec),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .text_char_o (text_char_o),
    .last_o      (last_o)
  );

endmodule
